@@ rtl/orfe_pkg.sv @@
// shared types and constants for the ook remote frame encoder
// used by orfe_front, orfe_back and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package orfe_pkg;

  localparam int TX_CODE_W  = 26;
  localparam int CODE_MAX_W = 32;
  localparam int SYM_W      = 2;
  localparam int COUNT_W    = 3;

  typedef enum logic [SYM_W-1:0] {
    SYM_SHORT = 2'd0,
    SYM_ZERO  = 2'd1,
    SYM_SYNC  = 2'd2,
    SYM_PAUSE = 2'd3
  } sym_t;

  localparam logic [COUNT_W-1:0] COUNT_PAIR  = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_GROUP = 3'd4;

  typedef struct packed {
    sym_t                s0;
    sym_t                s1;
    sym_t                s2;
    sym_t                s3;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } res_t;

  function automatic res_t sync_res();
    res_t r;
    r = '{s0: SYM_SHORT, s1: SYM_SYNC, s2: SYM_SHORT, s3: SYM_SHORT,
          count: COUNT_PAIR, last: 1'b0};
    return r;
  endfunction

  function automatic res_t pause_res();
    res_t r;
    r = '{s0: SYM_SHORT, s1: SYM_PAUSE, s2: SYM_SHORT, s3: SYM_SHORT,
          count: COUNT_PAIR, last: 1'b1};
    return r;
  endfunction

  // one bit: short,zero,short,short; zero bit: short,short,short,zero
  function automatic res_t bit_res(input logic b);
    res_t r;
    r.s0    = SYM_SHORT;
    r.s1    = b ? SYM_ZERO : SYM_SHORT;
    r.s2    = SYM_SHORT;
    r.s3    = b ? SYM_SHORT : SYM_ZERO;
    r.count = COUNT_GROUP;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/orfe_front.sv @@
// front end: accepts commands and packs them into the frame bit word
// uses orfe_pkg; feeds the command queue
`timescale 1ns / 1ps
`default_nettype none

module orfe_front
  import orfe_pkg::*;
#(
  parameter int CODE_BITS = 26
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [TX_CODE_W-1:0]    tx_code,
  input  wire logic                    command_on,
  input  wire logic [1:0]              channel,
  input  wire logic [1:0]              unit,
  output logic                         q_push,
  output logic [CODE_BITS+5:0]         q_data,
  input  wire logic                    q_full
);

  localparam int FRAME_BITS = CODE_BITS + 6;

  logic                    hold_valid;
  logic [FRAME_BITS-1:0]   hold_word;
  logic [CODE_MAX_W-1:0]   code_ext;
  logic                    accept;

  // code bits above the field go out as zeros
  assign code_ext = CODE_MAX_W'(tx_code);

  assign q_push = hold_valid && !q_full;
  assign full   = hold_valid && q_full;
  assign accept = push && !full;
  assign q_data = hold_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  // sent msb first: code, group bit, command, channel, unit
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_word <= {code_ext[CODE_BITS-1:0], 1'b0, command_on, channel, unit};
    end
  end

endmodule

`default_nettype wire

@@ rtl/orfe_queue.sv @@
// two-entry command queue between front and back end
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module orfe_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [WIDTH-1:0]  wr_data,
  output logic                   q_full,
  input  wire logic              rd_en,
  output logic [WIDTH-1:0]       rd_data,
  output logic                   q_empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign q_full  = (fill == 2'd2);
  assign q_empty = (fill == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/orfe_back.sv @@
// back end: walks one frame word into symbol results, one per cycle unless the result side stalls
// uses orfe_pkg; pulls from the command queue, holds the result register
`timescale 1ns / 1ps
`default_nettype none

module orfe_back
  import orfe_pkg::*;
#(
  parameter int CODE_BITS = 26
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [CODE_BITS+5:0]  q_data,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  output res_t                       res,
  output logic                       res_valid,
  input  wire logic                  res_pop
);

  localparam int FRAME_BITS = CODE_BITS + 6;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(FRAME_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BITS = 3'b010,
    ST_END  = 3'b100
  } state_t;

  state_t                 state;
  logic [FRAME_BITS-1:0]  shreg;
  logic [CNT_W-1:0]       left;
  logic                   advance;

  assign advance = !res_valid || res_pop;
  assign q_pop   = advance && (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else if (advance) begin
      unique case (state)
        ST_IDLE: begin
          res_valid <= !q_empty;
          if (!q_empty) begin
            state <= ST_BITS;
          end
        end
        ST_BITS: begin
          res_valid <= 1'b1;
          if (left == '0) begin
            state <= ST_END;
          end
        end
        ST_END: begin
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload side: frame bits shift out msb first
  always_ff @(posedge clk) begin
    if (advance) begin
      unique case (state)
        ST_IDLE: begin
          shreg <= q_data;
          left  <= CNT_START;
          res   <= sync_res();
        end
        ST_BITS: begin
          shreg <= {shreg[FRAME_BITS-2:0], 1'b0};
          left  <= left - CNT_ONE;
          res   <= bit_res(shreg[FRAME_BITS-1]);
        end
        ST_END: begin
          res <= pause_res();
        end
        default: res <= pause_res();
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ook_remote_frame_encoder.sv @@
// channel   | handshake         | payload
// ----------+-------------------+------------------------------------------
// command   | push / full       | tx_code, command_on, channel, unit
// result    | pop / empty       | sym_first..sym_fourth, symbol_count, last
//
// each command becomes CODE_BITS + 8 results (34 by default), one per cycle while pop keeps up;
// the back end sequencer emits one result a cycle unless the result side stalls,
// so a steady stream runs with no gap between frames.
// when idle, a command passes the holding register and a queue entry before its first result is registered.
// rst is synchronous and empties the holding register, the queue and the result register; no clearing pass.
// a stalled result side stops the sequencer; the front still takes
// up to three commands (holding register plus two queue entries).
// top level: front end, command queue and back end of the frame encoder
// uses orfe_pkg, orfe_front, orfe_queue, orfe_back
`timescale 1ns / 1ps
`default_nettype none

module ook_remote_frame_encoder
  import orfe_pkg::*;
#(
  parameter int CODE_BITS = 26
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [TX_CODE_W-1:0]  tx_code,
  input  wire logic                  command_on,
  input  wire logic [1:0]            channel,
  input  wire logic [1:0]            unit,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [SYM_W-1:0]           sym_first,
  output logic [SYM_W-1:0]           sym_second,
  output logic [SYM_W-1:0]           sym_third,
  output logic [SYM_W-1:0]           sym_fourth,
  output logic [COUNT_W-1:0]         symbol_count,
  output logic                       last
);

  localparam int FRAME_BITS = CODE_BITS + 6;

  logic                   q_push;
  logic [FRAME_BITS-1:0]  q_wdata;
  logic                   q_full;
  logic                   q_pop;
  logic [FRAME_BITS-1:0]  q_rdata;
  logic                   q_empty;
  res_t                   res;
  logic                   res_valid;

  orfe_front #(.CODE_BITS(CODE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .tx_code    (tx_code),
    .command_on (command_on),
    .channel    (channel),
    .unit       (unit),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  orfe_queue #(.WIDTH(FRAME_BITS)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  orfe_back #(.CODE_BITS(CODE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty        = !res_valid;
  assign sym_first    = res.s0;
  assign sym_second   = res.s1;
  assign sym_third    = res.s2;
  assign sym_fourth   = res.s3;
  assign symbol_count = res.count;
  assign last         = res.last;

endmodule

`default_nettype wire

@@ rtl/orfe_checker.sv @@
// port-level checks for ook_remote_frame_encoder, bound to the top level
// uses orfe_pkg for symbol codes and counts
`timescale 1ns / 1ps
`default_nettype none

module orfe_checker
  import orfe_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                empty,
  input wire logic                pop,
  input wire logic [SYM_W-1:0]    sym_first,
  input wire logic [SYM_W-1:0]    sym_second,
  input wire logic [SYM_W-1:0]    sym_third,
  input wire logic [SYM_W-1:0]    sym_fourth,
  input wire logic [COUNT_W-1:0]  symbol_count,
  input wire logic                last
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sym_first) && $stable(sym_second)
      && $stable(sym_third) && $stable(sym_fourth)
      && $stable(symbol_count) && $stable(last)))
    else $error("waiting result changed");

  // every result starts short and has a count of two or four
  a_shape: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (sym_first == SYM_SHORT
      && (symbol_count == COUNT_PAIR || symbol_count == COUNT_GROUP)))
    else $error("bad result shape");

  // the closing pair carries the pause
  a_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (symbol_count == COUNT_PAIR && sym_second == SYM_PAUSE))
    else $error("closing result malformed");

  // after the closing transfer the next frame opens with sync
  a_next_sync: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && last) ##1 !empty |-> (sym_second == SYM_SYNC && !last))
    else $error("frame did not open with sync");

endmodule

bind ook_remote_frame_encoder orfe_checker u_orfe_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .sym_first    (sym_first),
  .sym_second   (sym_second),
  .sym_third    (sym_third),
  .sym_fourth   (sym_fourth),
  .symbol_count (symbol_count),
  .last         (last)
);

`default_nettype wire

@@ bench/tb_ook_remote_frame_encoder.sv @@
// self-checking bench for ook_remote_frame_encoder: commands in, symbol groups out
// depends on orfe_pkg for the symbol enum, count codes and result struct
`timescale 1ns / 1ps

module tb_ook_remote_frame_encoder;
  import orfe_pkg::*;

  localparam int CODE_BITS  = 26;
  localparam int N_DIRECTED = 12;
  localparam int N_RANDOM   = 350;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int MAX_SHOWN  = 10;
  localparam int NO_ONES    = -1;

  typedef struct {
    logic [TX_CODE_W-1:0] code;
    logic                 on;
    logic [1:0]           ch;
    logic [1:0]           un;
    int                   ones;
  } cmd_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [TX_CODE_W-1:0] tx_code = '0;
  logic                 command_on = 1'b0;
  logic [1:0]           channel = '0;
  logic [1:0]           unit = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [SYM_W-1:0]     sym_first;
  logic [SYM_W-1:0]     sym_second;
  logic [SYM_W-1:0]     sym_third;
  logic [SYM_W-1:0]     sym_fourth;
  logic [COUNT_W-1:0]   symbol_count;
  logic                 last;

  res_t     symbol_q[$];
  int       ones_q[$];
  cmd_row_t dir_rows[0:N_DIRECTED-1];
  int       mismatches = 0;
  int       frames_in = 0;
  int       groups_out = 0;
  int       frames_out = 0;
  int       ones_seen = 0;
  int       idle_cycles = 0;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;

  ook_remote_frame_encoder #(.CODE_BITS(CODE_BITS)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .tx_code(tx_code), .command_on(command_on), .channel(channel), .unit(unit),
    .empty(empty), .pop(pop),
    .sym_first(sym_first), .sym_second(sym_second), .sym_third(sym_third),
    .sym_fourth(sym_fourth), .symbol_count(symbol_count), .last(last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic res_t bit_group(input logic b);
    res_t g;
    g.s0    = SYM_SHORT;
    g.s1    = b ? SYM_ZERO : SYM_SHORT;
    g.s2    = SYM_SHORT;
    g.s3    = b ? SYM_SHORT : SYM_ZERO;
    g.count = COUNT_GROUP;
    g.last  = 1'b0;
    return g;
  endfunction

  // expand one command into its full frame of expected symbol groups
  function automatic void expand_command(input cmd_row_t c);
    res_t edge_pair;
    edge_pair.s0    = SYM_SHORT;
    edge_pair.s1    = SYM_SYNC;
    edge_pair.s2    = SYM_SHORT;
    edge_pair.s3    = SYM_SHORT;
    edge_pair.count = COUNT_PAIR;
    edge_pair.last  = 1'b0;
    symbol_q.push_back(edge_pair);
    for (int n = CODE_BITS - 1; n >= 0; n--) begin
      symbol_q.push_back(bit_group((n < TX_CODE_W) ? c.code[n] : 1'b0));
    end
    symbol_q.push_back(bit_group(1'b0));  // group bit is always 0
    symbol_q.push_back(bit_group(c.on));
    symbol_q.push_back(bit_group(c.ch[1]));
    symbol_q.push_back(bit_group(c.ch[0]));
    symbol_q.push_back(bit_group(c.un[1]));
    symbol_q.push_back(bit_group(c.un[0]));
    edge_pair.s1   = SYM_PAUSE;
    edge_pair.last = 1'b1;
    symbol_q.push_back(edge_pair);
    ones_q.push_back(c.ones);
  endfunction

  function automatic void flag_field(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("[%0t] %s mismatch: expected %0d, got %0d (frame %0d)",
               $realtime, what, exp_v, act_v, frames_out);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic cmd_row_t random_command();
    cmd_row_t c;
    int kind;
    kind = $urandom_range(0, 9);
    c.code = TX_CODE_W'($urandom());
    c.on   = 1'($urandom_range(0, 1));
    c.ch   = 2'($urandom_range(0, 3));
    c.un   = 2'($urandom_range(0, 3));
    c.ones = NO_ONES;
    if (kind == 0)
      c.code = {{(TX_CODE_W-1){1'b0}}, 1'b1} << $urandom_range(0, TX_CODE_W - 1);
    else if (kind == 1)
      c.code = ~({{(TX_CODE_W-1){1'b0}}, 1'b1} << $urandom_range(0, TX_CODE_W - 1));
    else if (kind == 2)
      c.code = $urandom_range(0, 1) ? '1 : '0;
    return c;
  endfunction

  // one command transfer; push stays high across back-to-back commands
  task automatic offer(input cmd_row_t c);
    push       <= 1'b1;
    tx_code    <= c.code;
    command_on <= c.on;
    channel    <= c.ch;
    unit       <= c.un;
    do @(posedge clk); while (!(push && !full));
    expand_command(c);
    frames_in++;
  endtask

  task automatic idle_after(input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && pop && !empty) begin
      if (symbol_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("[%0t] result with no command behind it: %0d %0d %0d %0d cnt %0d last %0d",
                   $realtime, sym_first, sym_second, sym_third, sym_fourth,
                   symbol_count, last);
      end else begin
        e = symbol_q.pop_front();
        groups_out++;
        if (sym_first !== e.s0)
          flag_field("sym_first", int'(e.s0), int'(sym_first));
        if (sym_second !== e.s1)
          flag_field("sym_second", int'(e.s1), int'(sym_second));
        if (sym_third !== e.s2)
          flag_field("sym_third", int'(e.s2), int'(sym_third));
        if (sym_fourth !== e.s3)
          flag_field("sym_fourth", int'(e.s3), int'(sym_fourth));
        if (symbol_count !== e.count)
          flag_field("symbol_count", int'(e.count), int'(symbol_count));
        if (last !== e.last)
          flag_field("last", int'(e.last), int'(last));
        if (symbol_count === COUNT_GROUP && sym_second === SYM_ZERO) ones_seen++;
        if (e.last) begin
          if (ones_q.size() != 0 && ones_q[0] != NO_ONES && ones_q[0] != ones_seen)
            flag_field("one-bit count", ones_q[0], ones_seen);
          if (ones_q.size() != 0) void'(ones_q.pop_front());
          ones_seen = 0;
          frames_out++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d groups outstanding",
                 IDLE_LIMIT, symbol_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: bursts of pop with short and occasional long stalls
  initial begin
    int run_len;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end
      run_len = $urandom_range(1, 40);
      pop <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // command side
  initial begin
    cmd_row_t c;
    dir_rows = '{
      '{code: 26'h0000000, on: 1'b0, ch: 2'd0, un: 2'd0, ones: 0},
      '{code: 26'h3FFFFFF, on: 1'b1, ch: 2'd3, un: 2'd3, ones: 31},
      '{code: 26'h2000000, on: 1'b0, ch: 2'd0, un: 2'd0, ones: 1},
      '{code: 26'h0000001, on: 1'b0, ch: 2'd0, un: 2'd0, ones: 1},
      '{code: 26'h2AAAAAA, on: 1'b0, ch: 2'd2, un: 2'd2, ones: 15},
      '{code: 26'h1555555, on: 1'b1, ch: 2'd1, un: 2'd1, ones: 16},
      '{code: 26'h0000000, on: 1'b1, ch: 2'd0, un: 2'd0, ones: 1},
      '{code: 26'h3FFFFFF, on: 1'b0, ch: 2'd0, un: 2'd0, ones: 26},
      '{code: 26'h1234567, on: 1'b1, ch: 2'd1, un: 2'd2, ones: NO_ONES},
      '{code: 26'h2C0FFEE, on: 1'b0, ch: 2'd2, un: 2'd1, ones: NO_ONES},
      '{code: 26'h00F0F0F, on: 1'b1, ch: 2'd3, un: 2'd0, ones: NO_ONES},
      '{code: 26'h3E00001, on: 1'b0, ch: 2'd0, un: 2'd3, ones: NO_ONES}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(dir_rows[i]);
      idle_after(pick_gap());
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) begin
        // stall the result side and keep offering until the hold ends, so the input backs up
        hold_req = 1'b1;
        while (!hold_done) begin
          offer(random_command());
        end
      end
      if (i == 220) begin
        push <= 1'b0;
        while (symbol_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      offer(random_command());
      idle_after(pick_gap());
    end

    push <= 1'b0;
    while (symbol_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d commands (%0d directed), %0d frames and %0d symbol groups checked",
             frames_in, N_DIRECTED, frames_out, groups_out);
    $display("input backpressure and full drain exercised, %0d mismatches",
             mismatches);
    if (mismatches == 0 && symbol_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
